### design/sjpf_pkg.sv
// Shared types, constants and packet byte tables for the servo jog packet framer.
// No dependencies; every other design file imports this package.
package sjpf_pkg;

   localparam int NUM_JOINTS  = 6;
   localparam int JIDX_W      = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = QPTR_W + 1;
   localparam int CSR_ADDR_W  = 2;
   localparam int CSR_DATA_W  = 10;

   localparam logic [CSR_ADDR_W-1:0] CSR_JOG_SPEED   = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_FINE_STEP   = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_COARSE_STEP = 2'd2;

   localparam logic [9:0] JOG_SPEED_RST   = 10'd80;
   localparam logic [7:0] FINE_STEP_RST   = 8'd10;
   localparam logic [7:0] COARSE_STEP_RST = 8'd50;

   localparam logic [9:0] POS_RST      = 10'h1FF;
   localparam logic [9:0] POS_PICK_ARM = 10'h288;
   localparam logic [9:0] POS_PICK_SGL = 10'h1FF;
   localparam logic [9:0] POS_MAX      = 10'd1023;

   localparam logic [4:0] PAIR_LEN   = 5'd18;
   localparam logic [4:0] SINGLE_LEN = 5'd11;
   localparam logic [2:0] PICK_LAST  = 3'd4;

   localparam logic [7:0] HDR_BYTE      = 8'hFF;
   localparam logic [7:0] ID_BROADCAST  = 8'hFE;
   localparam logic [7:0] LEN_SYNC      = 8'h0E;
   localparam logic [7:0] LEN_WRITE     = 8'h07;
   localparam logic [7:0] INST_WRITE    = 8'h03;
   localparam logic [7:0] INST_SYNC     = 8'h83;
   localparam logic [7:0] ADDR_GOAL_POS = 8'h1E;
   localparam logic [7:0] SYNC_DATA_LEN = 8'h04;

   typedef struct packed {
      logic       func;
      logic [2:0] joint;
      logic       direction;
      logic       amplified;
   } req_data_type;

   typedef struct packed {
      logic [7:0] byte0;
      logic [7:0] byte1;
      logic [7:0] byte2;
      logic [7:0] byte3;
      logic [2:0] byte_count;
      logic       end_of_packet;
      logic       last;
   } rsp_data_type;

   typedef struct packed {
      logic       is_pair;
      logic [7:0] id_a;
      logic [7:0] id_b;
      logic [9:0] pos;
      logic [9:0] spd;
      logic       last;
   } pkt_desc_type;

   typedef enum logic {
      FRONT_IDLE,
      FRONT_PICKUP
   } front_state_type;

   function automatic pkt_desc_type sjpf_jog_desc(input logic [2:0] jidx,
                                                  input logic [9:0] pos,
                                                  input logic [9:0] spd);
      pkt_desc_type d;
      d.pos  = pos;
      d.spd  = spd;
      d.last = 1'b1;
      d.is_pair = 1'b0;
      d.id_b = 8'd0;
      unique case (jidx)
         3'd0: d.id_a = 8'd1;
         3'd1: begin d.is_pair = 1'b1; d.id_a = 8'd2; d.id_b = 8'd3; end
         3'd2: begin d.is_pair = 1'b1; d.id_a = 8'd4; d.id_b = 8'd5; end
         3'd3: d.id_a = 8'd6;
         3'd4: d.id_a = 8'd7;
         3'd5: d.id_a = 8'd8;
         default: d.id_a = 8'd0;
      endcase
      return d;
   endfunction

   function automatic pkt_desc_type sjpf_pick_desc(input logic [2:0] idx);
      pkt_desc_type d;
      d.is_pair = 1'b0;
      d.id_b    = 8'd0;
      d.pos     = POS_PICK_SGL;
      d.spd     = 10'h0F0;
      d.last    = 1'b0;
      unique case (idx)
         3'd0: begin d.is_pair = 1'b1; d.id_a = 8'd2; d.id_b = 8'd3; d.pos = POS_PICK_ARM; end
         3'd1: begin d.is_pair = 1'b1; d.id_a = 8'd4; d.id_b = 8'd5; d.pos = POS_PICK_ARM; end
         3'd2: d.id_a = 8'd6;
         3'd3: begin d.id_a = 8'd7; d.spd = 10'h150; end
         3'd4: begin d.id_a = 8'd8; d.spd = 10'h050; d.last = 1'b1; end
         default: d.id_a = 8'd0;
      endcase
      return d;
   endfunction

   function automatic logic signed [11:0] sjpf_lim_lo(input logic [2:0] jidx);
      return (jidx == 3'd1 || jidx == 3'd2) ? 12'sh0CD : 12'sh000;
   endfunction

   function automatic logic signed [11:0] sjpf_lim_hi(input logic [2:0] jidx);
      return (jidx == 3'd1 || jidx == 3'd2) ? 12'sh322 : 12'sh3FF;
   endfunction

   // Packet byte k, checksum excluded.
   function automatic logic [7:0] sjpf_byte(input pkt_desc_type d, input logic [4:0] k);
      logic [9:0] mir;
      logic [7:0] b;
      mir = POS_MAX - d.pos;
      b   = 8'd0;
      if (d.is_pair) begin
         unique case (k)
            5'd0, 5'd1: b = HDR_BYTE;
            5'd2:  b = ID_BROADCAST;
            5'd3:  b = LEN_SYNC;
            5'd4:  b = INST_SYNC;
            5'd5:  b = ADDR_GOAL_POS;
            5'd6:  b = SYNC_DATA_LEN;
            5'd7:  b = d.id_a;
            5'd8:  b = d.pos[7:0];
            5'd9:  b = {6'd0, d.pos[9:8]};
            5'd10: b = d.spd[7:0];
            5'd11: b = {6'd0, d.spd[9:8]};
            5'd12: b = d.id_b;
            5'd13: b = mir[7:0];
            5'd14: b = {6'd0, mir[9:8]};
            5'd15: b = d.spd[7:0];
            5'd16: b = {6'd0, d.spd[9:8]};
            default: b = 8'd0;
         endcase
      end else begin
         unique case (k)
            5'd0, 5'd1: b = HDR_BYTE;
            5'd2: b = d.id_a;
            5'd3: b = LEN_WRITE;
            5'd4: b = INST_WRITE;
            5'd5: b = ADDR_GOAL_POS;
            5'd6: b = d.pos[7:0];
            5'd7: b = {6'd0, d.pos[9:8]};
            5'd8: b = d.spd[7:0];
            5'd9: b = {6'd0, d.spd[9:8]};
            default: b = 8'd0;
         endcase
      end
      return b;
   endfunction

endpackage

### design/sjpf_front.sv
// Command front end: joint position state, jog limit check, packet descriptor issue.
// Depends on sjpf_pkg.
module sjpf_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  sjpf_pkg::req_data_type req_data,
   input  logic [9:0]            jog_speed,
   input  logic [7:0]            fine_step,
   input  logic [7:0]            coarse_step,
   input  logic                  q_full,
   output logic                  q_push,
   output sjpf_pkg::pkt_desc_type q_desc
);
   import sjpf_pkg::*;

   front_state_type   state_ff, state_in;
   logic [2:0]        cnt_ff, cnt_in;
   logic [9:0]        pos_ff [NUM_JOINTS];
   logic              accept;
   logic [2:0]        jidx;
   logic              joint_ok;
   logic [9:0]        cur;
   logic [7:0]        step;
   logic signed [11:0] nv;
   logic              jog_ok;

   assign accept   = req_valid && req_ready;
   assign jidx     = req_data.joint - 3'd1;
   assign joint_ok = (req_data.joint != 3'd0) && (req_data.joint <= 3'd6) &&
                     (req_data.joint <= 3'(NUM_JOINTS));
   assign cur      = pos_ff[jidx[JIDX_W-1:0]];
   assign step     = req_data.amplified ? coarse_step : fine_step;
   assign nv       = req_data.direction ? $signed({2'b00, cur}) + $signed({4'h0, step})
                                        : $signed({2'b00, cur}) - $signed({4'h0, step});
   assign jog_ok   = joint_ok && (nv > sjpf_lim_lo(jidx)) && (nv < sjpf_lim_hi(jidx));

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         FRONT_IDLE: begin
            if (accept && req_data.func) begin
               state_in = FRONT_PICKUP;
               cnt_in   = 3'd0;
            end
         end
         FRONT_PICKUP: begin
            if (!q_full) begin
               cnt_in = cnt_ff + 3'd1;
               if (cnt_ff == PICK_LAST) state_in = FRONT_IDLE;
            end
         end
         default: state_in = FRONT_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      q_push    = 1'b0;
      q_desc    = sjpf_jog_desc(jidx, nv[9:0], jog_speed);
      unique case (state_ff)
         FRONT_IDLE: begin
            req_ready = !q_full;
            q_push    = accept && !req_data.func && jog_ok;
         end
         FRONT_PICKUP: begin
            q_push = !q_full;
            q_desc = sjpf_pick_desc(cnt_ff);
         end
         default: req_ready = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FRONT_IDLE;
         cnt_ff   <= 3'd0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_JOINTS; i++) pos_ff[i] <= POS_RST;
      end else if (accept) begin
         for (int i = 0; i < NUM_JOINTS; i++) begin
            if (req_data.func) begin
               if (i == 1 || i == 2) pos_ff[i] <= POS_PICK_ARM;
               else if (i >= 3 && i <= 5) pos_ff[i] <= POS_PICK_SGL;
            end else if (jog_ok && jidx == 3'(i)) begin
               pos_ff[i] <= nv[9:0];
            end
         end
      end
   end

endmodule

### design/sjpf_queue.sv
// Descriptor queue between the command front end and the packet serializer.
// Depends on sjpf_pkg.
module sjpf_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  sjpf_pkg::pkt_desc_type push_desc,
   output logic                   full,
   input  logic                   pop,
   output logic                   head_valid,
   output sjpf_pkg::pkt_desc_type head_desc
);
   import sjpf_pkg::*;

   pkt_desc_type      slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ff, rd_ff;
   logic [QCNT_W-1:0] cnt_ff;
   logic              do_push, do_pop;

   assign full       = (cnt_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_valid = (cnt_ff != '0);
   assign head_desc  = slot_ff[rd_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ff] <= push_desc;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (do_push) wr_ff <= wr_ff + QPTR_W'(1);
         if (do_pop)  rd_ff <= rd_ff + QPTR_W'(1);
         case ({do_push, do_pop})
            2'b10:   cnt_ff <= cnt_ff + QCNT_W'(1);
            2'b01:   cnt_ff <= cnt_ff - QCNT_W'(1);
            default: cnt_ff <= cnt_ff;
         endcase
      end
   end

endmodule

### design/sjpf_back.sv
// Packet serializer: cuts each descriptor's packet into beats of up to four bytes
// and appends the inverted sum checksum. Depends on sjpf_pkg.
module sjpf_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_valid,
   input  sjpf_pkg::pkt_desc_type q_desc,
   output logic                   q_pop,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output sjpf_pkg::rsp_data_type rsp_data
);
   import sjpf_pkg::*;

   pkt_desc_type cur_ff;
   logic         active_ff, active_in;
   logic [4:0]   pos_ff, pos_in;
   logic [7:0]   sum_ff, sum_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_data_type rsp_ff, beat;
   logic [4:0]   len, rem;
   logic [4:0]   kk   [4];
   logic [7:0]   raw  [4];
   logic [7:0]   outb [4];
   logic         body [4];
   logic [7:0]   beat_sum, chk;
   logic         eop, adv;

   always_comb begin
      len = cur_ff.is_pair ? PAIR_LEN : SINGLE_LEN;
      rem = len - pos_ff;
      eop = (rem <= 5'd4);
      beat_sum = 8'd0;
      for (int j = 0; j < 4; j++) begin
         kk[j]   = pos_ff + 5'(j);
         raw[j]  = sjpf_byte(cur_ff, kk[j]);
         body[j] = (kk[j] >= 5'd2) && (kk[j] < len - 5'd1);
         beat_sum = beat_sum + (body[j] ? raw[j] : 8'd0);
      end
      chk = ~(sum_ff + beat_sum);
      for (int j = 0; j < 4; j++) begin
         if (kk[j] < len - 5'd1)       outb[j] = raw[j];
         else if (kk[j] == len - 5'd1) outb[j] = chk;
         else                          outb[j] = 8'd0;
      end
      beat.byte0         = outb[0];
      beat.byte1         = outb[1];
      beat.byte2         = outb[2];
      beat.byte3         = outb[3];
      beat.byte_count    = eop ? rem[2:0] : 3'd4;
      beat.end_of_packet = eop;
      beat.last          = eop && cur_ff.last;
   end

   assign adv   = active_ff && (!rsp_valid_ff || rsp_ready);
   assign q_pop = q_valid && (!active_ff || (adv && eop));

   always_comb begin
      active_in    = active_ff;
      pos_in       = pos_ff;
      sum_in       = sum_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (adv) begin
         rsp_valid_in = 1'b1;
         pos_in       = pos_ff + 5'd4;
         sum_in       = sum_ff + beat_sum;
         if (eop) active_in = 1'b0;
      end
      if (q_pop) begin
         active_in = 1'b1;
         pos_in    = 5'd0;
         sum_in    = 8'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pos_ff       <= 5'd0;
         sum_ff       <= 8'd0;
      end else begin
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
         pos_ff       <= pos_in;
         sum_ff       <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) cur_ff <= q_desc;
      if (adv)   rsp_ff <= beat;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

### design/servo_jog_packet_framer_core.sv
// Each descriptor passes the queue, then the serializer's descriptor and output registers.
// Throughput: one result beat per cycle from the serializer output register while rsp_ready
// is high and packets are pending; a jog gives 3 or 5 beats, a pickup 19.
// Commands are taken while the four-entry descriptor queue has room and no pickup is
// still being queued.
// Reset (synchronous, active high) sets all joints to 511 and the registers to their
// defaults, and empties the queue and the output register.
module servo_jog_packet_framer_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  sjpf_pkg::req_data_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output sjpf_pkg::rsp_data_type rsp_data,
   input  logic                   csr_we,
   input  logic [sjpf_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [sjpf_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import sjpf_pkg::*;

   logic [9:0]   jog_speed_ff;
   logic [7:0]   fine_step_ff, coarse_step_ff;
   logic         q_full, q_push, q_valid, q_pop;
   pkt_desc_type push_desc, head_desc;

   always_ff @(posedge clock) begin
      if (reset) begin
         jog_speed_ff   <= JOG_SPEED_RST;
         fine_step_ff   <= FINE_STEP_RST;
         coarse_step_ff <= COARSE_STEP_RST;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_JOG_SPEED:   jog_speed_ff   <= csr_wdata;
            CSR_FINE_STEP:   fine_step_ff   <= csr_wdata[7:0];
            CSR_COARSE_STEP: coarse_step_ff <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   sjpf_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .jog_speed   (jog_speed_ff),
      .fine_step   (fine_step_ff),
      .coarse_step (coarse_step_ff),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_desc      (push_desc)
   );

   sjpf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_desc  (push_desc),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_desc  (head_desc)
   );

   sjpf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_desc    (head_desc),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

### design/sjpf_checker.sv
// Port-level checks on the result channel of the framer core, bound to the top level.
// Depends on sjpf_pkg.
module sjpf_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input sjpf_pkg::rsp_data_type rsp_data
);
   import sjpf_pkg::*;

   // hold a stalled beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result beat changed while stalled");

   a_last_eop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.last |-> rsp_data.end_of_packet)
      else $error("last beat without end of packet");

   a_short_eop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.byte_count != 3'd4 |->
         rsp_data.end_of_packet && rsp_data.byte_count != 3'd0)
      else $error("short beat inside a packet");

   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.byte_count == 3'd1 |->
         rsp_data.byte1 == 8'd0 && rsp_data.byte2 == 8'd0 && rsp_data.byte3 == 8'd0)
      else $error("unused bytes not zero");

endmodule

bind servo_jog_packet_framer_core sjpf_checker u_sjpf_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

### tb/sv/servo_jog_packet_framer_core_test.sv
// Self-checking testbench for servo_jog_packet_framer_core: arm commands in, packet chunks out.
// A built-in joint and packet model predicts every chunk; needs only sjpf_pkg and the core.
`timescale 1ns / 1ps

module servo_jog_packet_framer_core_test;
   import sjpf_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int LONG_STALL     = 200;
   localparam int SETTLE_CYCLES  = 12;
   localparam int PHASE_ITEMS    = 37;

   class framer_model;
      logic [9:0] joint_pos [0:7];
      logic [9:0] jog_speed;
      logic [7:0] fine_step;
      logic [7:0] coarse_step;
      rsp_data_type chunks_due [$];
      int mismatches;

      function new();
         foreach (joint_pos[k]) joint_pos[k] = POS_RST;
         jog_speed   = JOG_SPEED_RST;
         fine_step   = FINE_STEP_RST;
         coarse_step = COARSE_STEP_RST;
         mismatches  = 0;
      endfunction

      function int pending();
         return chunks_due.size();
      endfunction

      function void write_reg(logic [CSR_ADDR_W-1:0] addr, int value);
         case (addr)
            CSR_JOG_SPEED:   jog_speed   = 10'(value);
            CSR_FINE_STEP:   fine_step   = 8'(value);
            CSR_COARSE_STEP: coarse_step = 8'(value);
            default: ;
         endcase
      endfunction

      protected function void frame(bit pair, logic [7:0] id_a, logic [7:0] id_b,
                                    logic [9:0] pos, logic [9:0] spd, bit closes);
         logic [7:0] pkt [$];
         logic [9:0] mir;
         logic [7:0] sum;
         rsp_data_type c;
         int k;
         mir = POS_MAX - pos;
         pkt.push_back(HDR_BYTE);
         pkt.push_back(HDR_BYTE);
         if (pair) begin
            pkt.push_back(ID_BROADCAST);
            pkt.push_back(LEN_SYNC);
            pkt.push_back(INST_SYNC);
            pkt.push_back(ADDR_GOAL_POS);
            pkt.push_back(SYNC_DATA_LEN);
            pkt.push_back(id_a);
            pkt.push_back(pos[7:0]);
            pkt.push_back({6'd0, pos[9:8]});
            pkt.push_back(spd[7:0]);
            pkt.push_back({6'd0, spd[9:8]});
            pkt.push_back(id_b);
            pkt.push_back(mir[7:0]);
            pkt.push_back({6'd0, mir[9:8]});
         end else begin
            pkt.push_back(id_a);
            pkt.push_back(LEN_WRITE);
            pkt.push_back(INST_WRITE);
            pkt.push_back(ADDR_GOAL_POS);
            pkt.push_back(pos[7:0]);
            pkt.push_back({6'd0, pos[9:8]});
         end
         pkt.push_back(spd[7:0]);
         pkt.push_back({6'd0, spd[9:8]});
         sum = 8'h00;
         for (k = 2; k < pkt.size(); k++) sum += pkt[k];
         pkt.push_back(~sum);
         for (k = 0; k < pkt.size(); k += 4) begin
            c = '0;
            c.byte_count = 3'(((pkt.size() - k) > 4) ? 4 : (pkt.size() - k));
            c.byte0 = pkt[k];
            if (c.byte_count > 1) c.byte1 = pkt[k + 1];
            if (c.byte_count > 2) c.byte2 = pkt[k + 2];
            if (c.byte_count > 3) c.byte3 = pkt[k + 3];
            c.end_of_packet = (k + 4 >= pkt.size());
            c.last = c.end_of_packet && closes;
            chunks_due.push_back(c);
         end
      endfunction

      function void note_command(req_data_type cmd);
         int idx;
         int nv;
         int lo;
         int hi;
         logic [7:0] step;
         if (cmd.func) begin
            frame(1'b1, 8'd2, 8'd3, POS_PICK_ARM, 10'h0F0, 1'b0);
            frame(1'b1, 8'd4, 8'd5, POS_PICK_ARM, 10'h0F0, 1'b0);
            frame(1'b0, 8'd6, 8'd0, POS_PICK_SGL, 10'h0F0, 1'b0);
            frame(1'b0, 8'd7, 8'd0, POS_PICK_SGL, 10'h150, 1'b0);
            frame(1'b0, 8'd8, 8'd0, POS_PICK_SGL, 10'h050, 1'b1);
            for (idx = 1; idx < 6; idx++)
               if (idx < NUM_JOINTS) joint_pos[idx] = (idx < 3) ? POS_PICK_ARM : POS_PICK_SGL;
         end else if (cmd.joint >= 1 && cmd.joint <= 6 && cmd.joint <= NUM_JOINTS) begin
            idx  = int'(cmd.joint) - 1;
            step = cmd.amplified ? coarse_step : fine_step;
            nv   = cmd.direction ? int'(joint_pos[idx]) + int'(step)
                                 : int'(joint_pos[idx]) - int'(step);
            lo   = (idx == 1 || idx == 2) ? 'hCD : 0;
            hi   = (idx == 1 || idx == 2) ? 'h322 : 1023;
            if (nv > lo && nv < hi) begin
               joint_pos[idx] = 10'(nv);
               case (idx)
                  1: frame(1'b1, 8'd2, 8'd3, 10'(nv), jog_speed, 1'b1);
                  2: frame(1'b1, 8'd4, 8'd5, 10'(nv), jog_speed, 1'b1);
                  0: frame(1'b0, 8'd1, 8'd0, 10'(nv), jog_speed, 1'b1);
                  default: frame(1'b0, 8'(idx + 3), 8'd0, 10'(nv), jog_speed, 1'b1);
               endcase
            end
         end
      endfunction

      function void check_chunk(rsp_data_type got);
         rsp_data_type want;
         logic [7:0] w [7];
         logic [7:0] g [7];
         string names [7] = '{"byte0", "byte1", "byte2", "byte3",
                              "byte_count", "end_of_packet", "last"};
         int k;
         if (chunks_due.size() == 0) begin
            $display("%0t ns: chunk with nothing expected: expected none, got %p", $time, got);
            mismatches++;
            return;
         end
         want = chunks_due.pop_front();
         w = '{want.byte0, want.byte1, want.byte2, want.byte3,
               8'(want.byte_count), 8'(want.end_of_packet), 8'(want.last)};
         g = '{got.byte0, got.byte1, got.byte2, got.byte3,
               8'(got.byte_count), 8'(got.end_of_packet), 8'(got.last)};
         for (k = 0; k < 7; k++)
            if (g[k] !== w[k]) begin
               $display("%0t ns: %s expected %0h got %0h", $time, names[k], w[k], g[k]);
               mismatches++;
            end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_data_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_data_type rsp_data;
   logic csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   framer_model model;
   int idle_cycles = 0;
   int sent = 0;
   bit long_stall_wanted = 1'b0;
   bit long_stall_done = 1'b0;
   int stall_left = 0;
   int rx_tick = 0;
   bit rx_free = 1'b1;
   logic [31:0] rx_pattern = '1;

   servo_jog_packet_framer_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) model.note_command(req_data);
         if (rsp_valid && rsp_ready) model.check_chunk(rsp_data);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   // Receiver: free-running or patterned stalls, reshuffled each time rx_tick wraps to zero.
   always @(negedge clock) begin
      if (long_stall_wanted && !long_stall_done) begin
         stall_left = LONG_STALL;
         long_stall_done = 1'b1;
      end
      if (rx_tick == 0) begin
         rx_free = ($urandom_range(0, 3) == 0);
         rx_pattern = $urandom;
      end
      rx_tick = (rx_tick + 1) % 64;
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= rx_free ? 1'b1 : rx_pattern[rx_tick % 32];
      end
   end

   function automatic req_data_type arm_cmd(bit f, int j, bit d, bit a);
      req_data_type c;
      c.func      = f;
      c.joint     = 3'(j);
      c.direction = d;
      c.amplified = a;
      return c;
   endfunction

   function automatic req_data_type random_cmd();
      req_data_type c;
      int r;
      r = $urandom_range(0, 99);
      c.direction = 1'($urandom);
      c.amplified = 1'($urandom);
      if (r < 10) begin
         c.func  = 1'b1;
         c.joint = 3'($urandom_range(0, 7));
      end else if (r < 18) begin
         c.func  = 1'b0;
         c.joint = ($urandom_range(0, 1) == 0) ? 3'd0 : 3'd7;
      end else begin
         c.func  = 1'b0;
         c.joint = 3'($urandom_range(1, 6));
      end
      return c;
   endfunction

   function automatic int corner_or_random(int top, int lo, int hi);
      int r;
      r = $urandom_range(0, 4);
      if (r == 0) return 0;
      if (r == 1) return top;
      return $urandom_range(lo, hi);
   endfunction

   // Call at a falling edge; returns at the falling edge after the beat is taken.
   task automatic offer(input req_data_type c);
      req_valid <= 1'b1;
      req_data  <= c;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic pause_sender(input int n);
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(negedge clock);
      end
   endtask

   task automatic set_reg(input logic [CSR_ADDR_W-1:0] addr, input int value);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= CSR_DATA_W'(value);
      model.write_reg(addr, value);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (model.pending() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic reconfigure(input int speed, input int fine, input int coarse);
      drain();
      set_reg(CSR_JOG_SPEED, speed);
      set_reg(CSR_FINE_STEP, fine);
      set_reg(CSR_COARSE_STEP, coarse);
      csr_we <= 1'b0;
   endtask

   initial begin
      int phase;
      int target;
      int burst;
      model = new();
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset registers: every joint once, invalid joints, pickup
      offer(arm_cmd(0, 1, 1, 0));
      offer(arm_cmd(0, 2, 1, 1));
      offer(arm_cmd(0, 3, 0, 0));
      offer(arm_cmd(0, 4, 0, 1));
      offer(arm_cmd(0, 5, 1, 0));
      offer(arm_cmd(0, 6, 0, 0));
      offer(arm_cmd(0, 0, 1, 1));
      offer(arm_cmd(0, 7, 1, 1));
      offer(arm_cmd(1, 7, 1, 1));
      offer(arm_cmd(1, 0, 0, 0));

      // widest steps: walk joints up to and past their limits
      reconfigure(1023, 255, 255);
      offer(arm_cmd(0, 1, 1, 1));
      offer(arm_cmd(0, 1, 1, 1));
      offer(arm_cmd(0, 2, 0, 1));
      offer(arm_cmd(0, 2, 0, 1));
      offer(arm_cmd(0, 4, 1, 1));
      offer(arm_cmd(0, 4, 1, 1));
      offer(arm_cmd(0, 4, 1, 1));
      offer(arm_cmd(0, 5, 0, 1));
      offer(arm_cmd(0, 5, 0, 1));
      offer(arm_cmd(0, 5, 0, 1));

      // zero steps and zero speed
      reconfigure(0, 0, 0);
      offer(arm_cmd(0, 3, 1, 0));
      offer(arm_cmd(0, 6, 0, 1));
      offer(arm_cmd(0, 2, 1, 1));

      for (phase = 0; phase < 5; phase++) begin
         reconfigure(corner_or_random(1023, 1, 1022),
                     corner_or_random(255, 1, 40),
                     corner_or_random(255, 20, 120));
         if (phase == 2) long_stall_wanted = 1'b1;
         target = sent + PHASE_ITEMS;
         while (sent < target) begin
            burst = $urandom_range(1, 8);
            if (burst > target - sent) burst = target - sent;
            repeat (burst) begin
               offer(random_cmd());
               sent++;
            end
            pause_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6));
         end
      end

      drain();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (model.mismatches == 0 && model.pending() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

### filelist.f
design/sjpf_pkg.sv
design/sjpf_front.sv
design/sjpf_queue.sv
design/sjpf_back.sv
design/servo_jog_packet_framer_core.sv
design/sjpf_checker.sv
tb/sv/servo_jog_packet_framer_core_test.sv
